// File: sv/kuz_pkg.sv
// Package: types, S-box tables and GF(2^8) helpers for the Kuznyechik engine.
package kuz_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] blk_type;

   localparam int NumRounds = 10;
   localparam int NumLanes = 16;
   localparam int NumConst = 32;
   localparam int CsrIdxW = 2;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEY0 = 2'd0,
      CSR_KEY1 = 2'd1,
      CSR_KEY2 = 2'd2,
      CSR_KEY3 = 2'd3
   } csr_idx_type;

   typedef enum logic {
      FUNC_ENC = 1'b0,
      FUNC_DEC = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_EXPAND,
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Cipher-side control between the sequencer and the lane datapath.
   typedef struct packed {
      logic       load;
      logic       dec;
      logic       mix;
      logic [3:0] step;
   } lane_ctl_type;

   localparam logic [7:0] SboxFwd [256] = '{
      8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,
      8'd35,8'd197,8'd4,8'd77,8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
      8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,8'd249,8'd24,8'd101,8'd90,
      8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
      8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,
      8'd127,8'd212,8'd211,8'd31,8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
      8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,8'd181,8'd112,8'd14,8'd86,
      8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
      8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,
      8'd157,8'd158,8'd178,8'd177,8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
      8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,8'd223,8'd245,8'd36,8'd169,
      8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
      8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,
      8'd78,8'd51,8'd10,8'd74,8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
      8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,8'd173,8'd69,8'd70,8'd146,
      8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
      8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,
      8'd136,8'd217,8'd231,8'd137,8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
      8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,8'd32,8'd113,8'd103,8'd164,
      8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
      8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,
      8'd57,8'd75,8'd99,8'd182
   };

   localparam logic [7:0] SboxRev [256] = '{
      8'd165,8'd45,8'd50,8'd143,8'd14,8'd48,8'd56,8'd192,8'd84,8'd230,8'd158,8'd57,
      8'd85,8'd126,8'd82,8'd145,8'd100,8'd3,8'd87,8'd90,8'd28,8'd96,8'd7,8'd24,
      8'd33,8'd114,8'd168,8'd209,8'd41,8'd198,8'd164,8'd63,8'd224,8'd39,8'd141,8'd12,
      8'd130,8'd234,8'd174,8'd180,8'd154,8'd99,8'd73,8'd229,8'd66,8'd228,8'd21,8'd183,
      8'd200,8'd6,8'd112,8'd157,8'd65,8'd117,8'd25,8'd201,8'd170,8'd252,8'd77,8'd191,
      8'd42,8'd115,8'd132,8'd213,8'd195,8'd175,8'd43,8'd134,8'd167,8'd177,8'd178,8'd91,
      8'd70,8'd211,8'd159,8'd253,8'd212,8'd15,8'd156,8'd47,8'd155,8'd67,8'd239,8'd217,
      8'd121,8'd182,8'd83,8'd127,8'd193,8'd240,8'd35,8'd231,8'd37,8'd94,8'd181,8'd30,
      8'd162,8'd223,8'd166,8'd254,8'd172,8'd34,8'd249,8'd226,8'd74,8'd188,8'd53,8'd202,
      8'd238,8'd120,8'd5,8'd107,8'd81,8'd225,8'd89,8'd163,8'd242,8'd113,8'd86,8'd17,
      8'd106,8'd137,8'd148,8'd101,8'd140,8'd187,8'd119,8'd60,8'd123,8'd40,8'd171,8'd210,
      8'd49,8'd222,8'd196,8'd95,8'd204,8'd207,8'd118,8'd44,8'd184,8'd216,8'd46,8'd54,
      8'd219,8'd105,8'd179,8'd20,8'd149,8'd190,8'd98,8'd161,8'd59,8'd22,8'd102,8'd233,
      8'd92,8'd108,8'd109,8'd173,8'd55,8'd97,8'd75,8'd185,8'd227,8'd186,8'd241,8'd160,
      8'd133,8'd131,8'd218,8'd71,8'd197,8'd176,8'd51,8'd250,8'd150,8'd111,8'd110,8'd194,
      8'd246,8'd80,8'd255,8'd93,8'd169,8'd142,8'd23,8'd27,8'd151,8'd125,8'd236,8'd88,
      8'd247,8'd31,8'd251,8'd124,8'd9,8'd13,8'd122,8'd103,8'd69,8'd135,8'd220,8'd232,
      8'd79,8'd29,8'd78,8'd4,8'd235,8'd248,8'd243,8'd62,8'd61,8'd189,8'd138,8'd136,
      8'd221,8'd205,8'd11,8'd19,8'd152,8'd2,8'd147,8'd128,8'd144,8'd208,8'd36,8'd52,
      8'd203,8'd237,8'd244,8'd206,8'd153,8'd16,8'd68,8'd64,8'd146,8'd58,8'd1,8'd38,
      8'd18,8'd26,8'd72,8'd104,8'd245,8'd129,8'd139,8'd199,8'd214,8'd32,8'd10,8'd8,
      8'd0,8'd76,8'd215,8'd116
   };

   localparam logic [7:0] LinCoef [16] = '{
      8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
      8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94, 8'h01
   };

   // Multiply in GF(2^8) modulo x^8+x^7+x^6+x+1.
   function automatic byte_type gf_mul(input byte_type a, input byte_type b);
      byte_type acc;
      byte_type x;
      acc = '0;
      x = a;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc = acc ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
      end
      return acc;
   endfunction

   // Byte k of a block, byte 0 most significant.
   function automatic byte_type blk_byte(input blk_type v, input int k);
      return v[127 - 8*k -: 8];
   endfunction

endpackage

// File: sv/kuz_lane.sv
// One byte lane: S-box and the GF product term this lane feeds to the merge.
module kuz_lane
   import kuz_pkg::*;
(
   input  byte_type sub_in,
   input  logic     dec,
   input  byte_type mul_in,
   input  byte_type coef,
   output byte_type sub_out,
   output byte_type term
);

   // Substitute the byte; form this lane's product for the linear sum.
   assign sub_out = dec ? SboxRev[sub_in] : SboxFwd[sub_in];
   assign term    = gf_mul(coef, mul_in);

endmodule

// File: sv/kuz_datapath.sv
// Round datapath: sixteen byte lanes, XOR merge of the linear sum, state register.
module kuz_datapath
   import kuz_pkg::*;
(
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  blk_type      load_blk,
   input  blk_type      rkey,
   output blk_type      state
);

   blk_type  state_ff, state_in;
   blk_type  keyed, subbed, mix_src;
   byte_type terms [NumLanes];
   byte_type lsum;
   blk_type  rot;

   // Add round key before substitution (encrypt) or before first shift (decrypt).
   assign keyed = state_ff ^ rkey;

   // Decrypt: rotate left by one byte, new last byte is the lane sum.
   assign rot = {state_ff[119:0], state_ff[127:120]};
   assign mix_src = ctl.dec ? rot : state_ff;

   genvar g;
   generate
      for (g = 0; g < NumLanes; g++) begin : g_lane
         kuz_lane u_lane (
            .sub_in (keyed[127 - 8*g -: 8]),
            .dec    (ctl.dec),
            .mul_in (mix_src[127 - 8*g -: 8]),
            .coef   (LinCoef[g]),
            .sub_out(subbed[127 - 8*g -: 8]),
            .term   (terms[g])
         );
      end
   endgenerate

   // Merge lane products.
   always_comb begin
      lsum = '0;
      for (int k = 0; k < NumLanes; k++) lsum = lsum ^ terms[k];
   end

   // Select next state; a decrypt step of zero is key XOR only, otherwise substitute.
   always_comb begin
      state_in = state_ff;
      if (ctl.load) begin
         state_in = load_blk;
      end else if (ctl.mix) begin
         if (ctl.dec) state_in = {rot[127:8], lsum};
         else         state_in = {lsum, state_ff[127:8]};
      end else if (ctl.dec && ctl.step == 4'd0) begin
         state_in = keyed;
      end else begin
         state_in = subbed;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign state = state_ff;

endmodule

// File: sv/kuznyechik_block_cipher_top.sv
// Top level: key registers, key expansion and cipher sequencer, round key store.
//
// Kuznyechik engine, one block at a time. The core is a 16-lane byte datapath
// that does one S-box layer or one of the sixteen linear shift steps per clock
// while it runs. An encrypt round is key XOR with S-box, then sixteen shifts; a
// decrypt round is key XOR, sixteen inverse shifts, inverse S-box. The result is
// held in out_ff with rsp_valid until taken, and the next item is taken only
// after the result has left, so any output stall delays the next item. After
// reset and after every key register write the same datapath expands the round
// keys in 32 Feistel steps, each building the constant and then doing the F step
// and swap; req_stall stays high throughout.
// Decryption applies the final XOR key 0 after nine inverse rounds.
module kuznyechik_block_cipher_top
   import kuz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low
);

   state_type    st_ff, st_in;
   logic [63:0]  key_ff [4];
   blk_type      rk_ff [NumRounds];
   blk_type      a_ff, a_in, b_ff, b_in;
   logic [5:0]   n_ff, n_in;        // expansion constant index 1..32
   logic [3:0]   rnd_ff, rnd_in;    // round counter
   logic [4:0]   ph_ff, ph_in;      // phase within a round
   logic         xk_ff, xk_in;      // expansion: 0 = build constant, 1 = F step
   logic         dec_ff, dec_in;
   logic         rkw;
   lane_ctl_type ctl;
   blk_type      load_blk, rkey, dstate;
   blk_type      out_ff, out_in;

   // Hold key registers; any write restarts expansion.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   kuz_datapath u_dp (
      .clock   (clock),
      .ctl     (ctl),
      .load_blk(load_blk),
      .rkey    (rkey),
      .state   (dstate)
   );

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_EXPAND;
         n_ff   <= 6'd1;
         rnd_ff <= '0;
         ph_ff  <= '0;
         xk_ff  <= 1'b0;
         dec_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         n_ff   <= n_in;
         rnd_ff <= rnd_in;
         ph_ff  <= ph_in;
         xk_ff  <= xk_in;
         dec_ff <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      out_ff <= out_in;
      if (rkw) begin
         rk_ff[{n_ff[5:3], 1'b0}]       <= a_in;
         rk_ff[{n_ff[5:3], 1'b0} + 4'd1] <= b_in;
      end
      if (st_ff == ST_EXPAND && n_ff == 6'd1 && ph_ff == 5'd0 && !xk_ff) begin
         rk_ff[0] <= {key_ff[0], key_ff[1]};
         rk_ff[1] <= {key_ff[2], key_ff[3]};
      end
   end

   // Encrypt round phase 0: substitute (after key XOR); phases 1..16: linear shifts.
   // Expansion: constant build = load c, 16 shifts;
   // F step = load a, key XOR c + S, 16 shifts, then b/a swap.
   always_comb begin
      st_in   = st_ff;
      n_in    = n_ff;
      rnd_in  = rnd_ff;
      ph_in   = ph_ff;
      xk_in   = xk_ff;
      dec_in  = dec_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      out_in  = out_ff;
      rkw     = 1'b0;
      ctl     = '{load: 1'b0, dec: 1'b0, mix: 1'b0, step: 4'd0};
      load_blk = '0;
      rkey    = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (st_ff)
         ST_EXPAND: begin
            if (n_ff == 6'd1 && ph_ff == 5'd0 && !xk_ff) begin
               a_in = {key_ff[0], key_ff[1]};
               b_in = {key_ff[2], key_ff[3]};
            end
            if (!xk_ff) begin
               // build constant C_n in the datapath, then hold it in out_ff
               if (ph_ff == 5'd0) begin
                  ctl.load = 1'b1;
                  load_blk = {122'd0, n_ff};
                  ph_in = 5'd1;
               end else begin
                  ctl.mix = 1'b1;
                  if (ph_ff == 5'd16) begin
                     ph_in = 5'd0;
                     xk_in = 1'b1;
                  end else begin
                     ph_in = ph_ff + 5'd1;
                  end
               end
            end else begin
               if (ph_ff == 5'd0) begin
                  out_in = dstate;   // constant
                  ctl.load = 1'b1;
                  load_blk = a_ff;
                  ph_in = 5'd1;
               end else if (ph_ff == 5'd1) begin
                  rkey = out_ff;
                  ph_in = 5'd2;
               end else if (ph_ff == 5'd18) begin
                  b_in = a_ff;
                  a_in = dstate ^ b_ff;
                  rkw = (n_ff[2:0] == 3'd0);
                  ph_in = 5'd0;
                  xk_in = 1'b0;
                  if (n_ff == 6'd32) begin
                     st_in = ST_IDLE;
                     n_in = 6'd1;
                  end else begin
                     n_in = n_ff + 6'd1;
                  end
               end else begin
                  ctl.mix = 1'b1;
                  ph_in = ph_ff + 5'd1;
               end
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               load_blk = {req_block_high, req_block_low};
               dec_in = (req_func == FUNC_DEC);
               rnd_in = '0;
               ph_in = '0;
               st_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.dec = dec_ff;
            if (!dec_ff) begin
               // round r: phase 0 XOR k_r + S, phases 1..16 shift; r==9 final XOR
               if (rnd_ff == 4'd9) begin
                  out_in = dstate ^ rk_ff[9];
                  st_in = ST_DONE;
               end else if (ph_ff == 5'd0) begin
                  rkey = rk_ff[rnd_ff];
                  ph_in = 5'd1;
               end else begin
                  ctl.mix = 1'b1;
                  if (ph_ff == 5'd16) begin
                     ph_in = '0;
                     rnd_in = rnd_ff + 4'd1;
                  end else begin
                     ph_in = ph_ff + 5'd1;
                  end
               end
            end else begin
               // inverse round: phase 0 XOR k_{9-r}, 1..16 inverse shifts, 17 S^-1
               if (rnd_ff == 4'd9) begin
                  out_in = dstate ^ rk_ff[0];
                  st_in = ST_DONE;
               end else if (ph_ff == 5'd0) begin
                  rkey = rk_ff[4'd9 - rnd_ff];
                  ph_in = 5'd1;
               end else if (ph_ff == 5'd17) begin
                  // substitute only: zero key, dec selects the inverse S-box, nonzero step the S-box path
                  ctl.dec = 1'b1;
                  ctl.step = 4'd1;
                  ph_in = '0;
                  rnd_in = rnd_ff + 4'd1;
               end else begin
                  ctl.mix = 1'b1;
                  ph_in = ph_ff + 5'd1;
               end
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_write) begin
         st_in = ST_EXPAND;
         n_in = 6'd1;
         ph_in = '0;
         xk_in = 1'b0;
         req_stall = 1'b1;
      end
   end

   assign rsp_result_high = out_ff[127:64];
   assign rsp_result_low  = out_ff[63:0];

endmodule

// File: bench/kuznyechik_block_cipher_top_test.sv
// Testbench for the Kuznyechik block cipher engine: keyed phases, random traffic, self-check.
`timescale 1ns / 1ps

module kuznyechik_block_cipher_top_test;
   import kuz_pkg::*;

   localparam int IdleLimit = 20000;
   localparam int HoldCycles = 900;
   localparam int PhaseItems = 280;
   localparam int NumPhases = 5;

   // Predicts every cipher result from its own copy of the key and round keys.
   class kuz_block_predictor;
      logic [63:0] key_word [4];
      blk_type round_key [NumRounds];
      blk_type expected_blocks [$];
      int mismatches;
      int checked;

      function new();
         mismatches = 0;
         checked = 0;
         foreach (key_word[i]) key_word[i] = '0;
         expand();
      endfunction

      function byte_type gmul(byte_type x, byte_type y);
         byte_type acc;
         acc = '0;
         for (int k = 0; k < 8; k++) begin
            if (y[k]) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
         end
         return acc;
      endfunction

      function byte_type lin_sum(blk_type v);
         byte_type acc;
         acc = '0;
         for (int k = 0; k < NumLanes; k++) acc ^= gmul(LinCoef[k], v[127 - 8*k -: 8]);
         return acc;
      endfunction

      function blk_type lin_fwd(blk_type v);
         for (int k = 0; k < NumLanes; k++) v = {lin_sum(v), v[127:8]};
         return v;
      endfunction

      function blk_type lin_rev(blk_type v);
         blk_type rot;
         for (int k = 0; k < NumLanes; k++) begin
            rot = {v[119:0], v[127:120]};
            v = {rot[127:8], lin_sum(rot)};
         end
         return v;
      endfunction

      function blk_type subst(blk_type v, bit inv);
         for (int k = 0; k < NumLanes; k++)
            v[8*k +: 8] = inv ? SboxRev[v[8*k +: 8]] : SboxFwd[v[8*k +: 8]];
         return v;
      endfunction

      // Rebuild the ten round keys from the four key words.
      function void expand();
         blk_type a, b, c, t;
         a = {key_word[0], key_word[1]};
         b = {key_word[2], key_word[3]};
         round_key[0] = a;
         round_key[1] = b;
         for (int n = 1; n <= 32; n++) begin
            c = lin_fwd(blk_type'(n));
            t = lin_fwd(subst(a ^ c, 1'b0)) ^ b;
            b = a;
            a = t;
            if (n % 8 == 0) begin
               round_key[n/4] = a;
               round_key[n/4 + 1] = b;
            end
         end
      endfunction

      function void set_key(csr_idx_type idx, logic [63:0] value);
         key_word[idx] = value;
         expand();
      endfunction

      function blk_type cipher(func_type f, blk_type v);
         if (f == FUNC_ENC) begin
            for (int r = 0; r < 9; r++) v = lin_fwd(subst(v ^ round_key[r], 1'b0));
            v ^= round_key[9];
         end else begin
            for (int r = 9; r >= 1; r--) v = subst(lin_rev(v ^ round_key[r]), 1'b1);
            v ^= round_key[0];
         end
         return v;
      endfunction

      function void note_block(func_type f, blk_type v);
         expected_blocks.push_back(cipher(f, v));
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
         mismatches++;
      endtask

      task check_result(logic [63:0] hi, logic [63:0] lo);
         blk_type want;
         if (expected_blocks.size() == 0) begin
            $display("unexpected result %h_%h", hi, lo);
            mismatches++;
         end else begin
            want = expected_blocks.pop_front();
            if (hi !== want[127:64]) report("result_high", hi, want[127:64]);
            if (lo !== want[63:0]) report("result_low", lo, want[63:0]);
         end
         checked++;
      endtask

      function int pending();
         return expected_blocks.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;

   kuz_block_predictor predictor = new();
   int burst_left = 0;
   int sent = 0;
   int key_writes = 0;
   int idle_cycles = 0;
   bit pressure_on = 1'b0;
   bit pressure_seen = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   kuznyechik_block_cipher_top u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_block_high(req_block_high), .req_block_low(req_block_low),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_high(rsp_result_high), .rsp_result_low(rsp_result_low)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check results and stall on a pattern that changes at random intervals, or hold off once.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         predictor.check_result(rsp_result_high, rsp_result_low);
      if (pressure_on && !pressure_seen) begin
         pressure_seen <= 1'b1;
         hold_left <= HoldCycles;
      end
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(16, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 1);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no traffic for %0d cycles", IdleLimit);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one item, hold it until accepted, then advance the burst.
   task send_block(func_type f, blk_type v);
      int gap;
      req_valid <= 1'b1;
      req_func <= f;
      req_block_high <= v[127:64];
      req_block_low <= v[63:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predictor.note_block(f, v);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 170) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and wait until every expected result has come back.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predictor.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_key(csr_idx_type idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      predictor.set_key(idx, value);
      key_writes++;
   endtask

   task load_key(logic [255:0] k);
      write_key(CSR_KEY0, k[255:192]);
      write_key(CSR_KEY1, k[191:128]);
      write_key(CSR_KEY2, k[127:64]);
      write_key(CSR_KEY3, k[63:0]);
   endtask

   // Field extremes, alternating patterns and the published test block, both ways.
   task directed_blocks();
      blk_type pats [6];
      pats[0] = '0;
      pats[1] = '1;
      pats[2] = {16{8'h55}};
      pats[3] = {16{8'hAA}};
      pats[4] = 128'h1122334455667700ffeeddccbbaa9988;
      pats[5] = 128'h7f679d90bebc24305a468d42b9d4edcd;
      foreach (pats[i]) begin
         send_block(FUNC_ENC, pats[i]);
         send_block(FUNC_DEC, pats[i]);
      end
   endtask

   function blk_type random_block();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom, $urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [255:0] k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero key from reset, then the published key.
      directed_blocks();
      drain();
      load_key(256'h8899aabbccddeeff0011223344556677_fedcba98765432100123456789abcdef);
      directed_blocks();
      drain();

      // Random phases under all-ones and random keys (phase 3 rewrites one key word); one phase holds off the receiver.
      for (int p = 0; p < NumPhases; p++) begin
         if (p == 0) k = '1;
         else k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         if (p == 3) write_key(CSR_KEY2, k[127:64]);
         else load_key(k);
         for (int i = 0; i < PhaseItems; i++) begin
            // start the hold-off once expansion is over and items are flowing
            if (p == 2 && i == 20) pressure_on = 1'b1;
            send_block(func_type'($urandom_range(0, 1)), random_block());
         end
         drain();
      end

      repeat (200) @(posedge clock);
      $display("covered %0d blocks in both directions under %0d key writes,", sent, key_writes);
      $display("%0d results checked with bursts, gaps and a long output hold-off", predictor.checked);
      if (predictor.mismatches == 0 && predictor.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
